[rtl/aisvdm_pkg.sv]
// aisvdm_pkg: shared constants, field types and the rate-of-turn table for the
// ais message 1 sentence decoder. no dependencies.

package aisvdm_pkg;

  // payload store
  localparam int BUFFER_BYTES = 21;
  localparam int CAP_BITS     = BUFFER_BYTES * 8;
  localparam int NSLOT        = (CAP_BITS + 5) / 6;  // six-bit character slots
  localparam int PAY_W        = NSLOT * 6;
  localparam int PTR_W        = $clog2(NSLOT + 1);

  // character codes
  localparam logic [7:0] CH_COMMA   = 8'd44;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] ARMOR_GAP  = 8'd40;
  localparam logic [7:0] ARMOR_SKIP = 8'd8;
  localparam logic [2:0] HEADER_COMMAS = 3'd5;

  localparam logic [5:0] MSG_ID_POSITION = 6'd1;

  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_BAD_ID = 1'b1
  } status_t;

  // field types
  typedef logic        [7:0]  ch_t;
  typedef logic        [1:0]  repeat_t;
  typedef logic        [29:0] mmsi_t;
  typedef logic        [3:0]  nav_status_t;
  typedef logic signed [14:0] rot_rate_t;
  typedef logic        [9:0]  speed_t;
  typedef logic        [1:0]  flags_t;
  typedef logic signed [27:0] lon_t;
  typedef logic signed [26:0] lat_t;
  typedef logic        [11:0] course_t;
  typedef logic        [8:0]  heading_t;
  typedef logic        [5:0]  second_t;

  // longitude fold above 180 degrees
  localparam lon_t              LON_FOLD = 28'sd108000000;
  localparam logic signed [28:0] LON_WRAP = 29'sd216000000;

  // rate of turn: (c / 4.733)^2 / 60 deg/s in 1/1024 units
  localparam logic signed [7:0] ROT_NONE    = -8'sd128;
  localparam logic signed [7:0] ROT_FAST_L  = -8'sd127;
  localparam logic signed [7:0] ROT_FAST_R  = 8'sd127;
  localparam rot_rate_t         TURN_FAST_L = -15'sd12288;
  localparam rot_rate_t         TURN_FAST_R = 15'sd12288;
  localparam logic [63:0]       TURN_NUM    = 64'd1024000000;
  localparam logic [63:0]       TURN_DEN    = 64'd1344077340;

  // 2^96 / (2 * den) rounded up: exact quotient for numerators below 2^64
  localparam logic [127:0] TURN_DEN2  = 128'd2 * 128'(TURN_DEN);
  localparam logic [127:0] TURN_RECIP = (128'd1 << 96) / TURN_DEN2 + 128'd1;

  typedef logic [13:0] turn_lut_t [0:127];

  // magnitude table, rounded half up, built at elaboration
  function automatic turn_lut_t build_turn_lut();
    turn_lut_t    lut;
    logic [127:0] x;
    logic [127:0] q;
    for (int i = 0; i < 128; i++) begin
      x      = 128'(2 * i * i) * 128'(TURN_NUM) + 128'(TURN_DEN);
      q      = (x * TURN_RECIP) >> 96;
      lut[i] = q[13:0];
    end
    return lut;
  endfunction

  localparam turn_lut_t TURN_LUT = build_turn_lut();

endpackage

[rtl/aisvdm_if.sv]
// aisvdm_if: valid/ready channels of the ais message 1 decoder, one for
// sentence characters and one for decoded reports. depends on aisvdm_pkg.

interface aisvdm_in_if;
  import aisvdm_pkg::*;

  logic valid;
  logic ready;
  ch_t  ch;
  logic sentence_last;
  logic message_last;

  modport source (output valid, ch, sentence_last, message_last, input ready);
  modport sink   (input valid, ch, sentence_last, message_last, output ready);
endinterface

interface aisvdm_out_if;
  import aisvdm_pkg::*;

  logic        valid;
  logic        ready;
  logic        status;
  repeat_t     repeat_count;
  mmsi_t       mmsi;
  nav_status_t nav_status;
  rot_rate_t   rot_rate;
  speed_t      speed;
  flags_t      flags;
  lon_t        lon_units;
  lat_t        lat_units;
  course_t     course;
  heading_t    heading;
  second_t     time_second;

  modport source (output valid, status, repeat_count, mmsi, nav_status, rot_rate, speed,
                  flags, lon_units, lat_units, course, heading, time_second,
                  input ready);
  modport sink   (input valid, status, repeat_count, mmsi, nav_status, rot_rate, speed,
                  flags, lon_units, lat_units, course, heading, time_second,
                  output ready);
endinterface

[rtl/ais_vdm_position_report_decoder.sv]
// ais_vdm_position_report_decoder: nmea aivdm/aivdo character stream to
// ais message 1 position reports. depends on aisvdm_pkg and aisvdm_if.
//
//   channel  dir  word                                        handshake
//   in_if    in   ch, sentence_last, message_last             valid/ready
//   out_if   out  status and eleven message 1 report fields   valid/ready
//
// one character per cycle while no message end waits: input register, then
// header/payload state update and report decode into the output register;
// a report is valid once the last word of its message has passed both registers.
// a character that does not end a message never waits on the output side;
// a message end waits only while an untaken report sits in the output register.
// synchronous active-low reset clears the state, the payload store and both
// valid bits; no clearing pass is needed.

module ais_vdm_position_report_decoder (
  input  logic         clk,
  input  logic         rst_n,
  aisvdm_in_if.sink    in_if,
  aisvdm_out_if.source out_if
);
  import aisvdm_pkg::*;

  // input register
  logic s1_valid_r, s1_valid_nxt;
  ch_t  s1_ch_r;
  logic s1_s_last_r;
  logic s1_m_last_r;

  // sentence / message state
  logic [2:0]       comma_count_r, comma_count_nxt;
  logic             in_payload_r, in_payload_nxt;
  logic [PTR_W-1:0] slot_ptr_r, slot_ptr_nxt;
  logic [PAY_W-1:0] payload_r, payload_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_status_r;
  repeat_t     out_repeat_r;
  mmsi_t       out_mmsi_r;
  nav_status_t out_nav_r;
  rot_rate_t   out_turn_r;
  speed_t      out_speed_r;
  flags_t      out_flags_r;
  lon_t        out_lon_r;
  lat_t        out_lat_r;
  course_t     out_course_r;
  heading_t    out_heading_r;
  second_t     out_second_r;

  logic        advance;
  logic        load_out;
  logic        accept_in;
  logic [7:0]  armor;
  logic [5:0]  sixbit;
  logic        write_slot;
  logic [PAY_W-1:0] merged;

  logic              id_ok;
  logic signed [7:0] rot_code;
  logic [6:0]        rot_mag;
  logic [13:0]       rot_q;
  rot_rate_t         turn_val;
  lon_t              lon_raw;
  logic signed [28:0] lon_wide;
  lon_t              lon_val;

  // a message end needs a free output slot, other characters always move on
  assign advance   = s1_valid_r && (!s1_m_last_r || !out_valid_r || out_if.ready);
  assign load_out  = advance && s1_m_last_r;
  assign in_if.ready = !s1_valid_r || advance;
  assign accept_in = in_if.valid && in_if.ready;

  assign s1_valid_nxt = accept_in ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_ch_r     <= in_if.ch;
      s1_s_last_r <= in_if.sentence_last;
      s1_m_last_r <= in_if.message_last;
    end
  end

  // de-armor: ascii to six bits
  always_comb begin
    armor = s1_ch_r - CH_ZERO;
    if (armor > ARMOR_GAP) begin
      armor = armor - ARMOR_SKIP;
    end
    sixbit = armor[5:0];
  end

  assign write_slot = in_payload_r && (s1_ch_r != CH_COMMA) &&
                      (slot_ptr_r < PTR_W'(NSLOT));

  // payload with this word's character in place, msb of the store is bit 0
  always_comb begin
    merged = payload_r;
    for (int k = 0; k < NSLOT; k++) begin
      if (write_slot && slot_ptr_r == PTR_W'(k)) begin
        merged[PAY_W-1-6*k -: 6] = sixbit;
      end
    end
  end

  always_comb begin
    comma_count_nxt = comma_count_r;
    in_payload_nxt  = in_payload_r;
    slot_ptr_nxt    = slot_ptr_r;
    payload_nxt     = payload_r;
    if (advance) begin
      payload_nxt = merged;
      if (in_payload_r) begin
        if (s1_ch_r == CH_COMMA) begin
          in_payload_nxt = 1'b0;
        end else if (write_slot) begin
          slot_ptr_nxt = slot_ptr_r + PTR_W'(1);
        end
      end else if (comma_count_r < HEADER_COMMAS && s1_ch_r == CH_COMMA) begin
        comma_count_nxt = comma_count_r + 3'd1;
        if (comma_count_r == HEADER_COMMAS - 3'd1) begin
          in_payload_nxt = 1'b1;
        end
      end
      if (s1_s_last_r || s1_m_last_r) begin
        comma_count_nxt = '0;
        in_payload_nxt  = 1'b0;
      end
      if (s1_m_last_r) begin
        slot_ptr_nxt = '0;
        payload_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comma_count_r <= '0;
      in_payload_r  <= 1'b0;
      slot_ptr_r    <= '0;
      payload_r     <= '0;
    end else begin
      comma_count_r <= comma_count_nxt;
      in_payload_r  <= in_payload_nxt;
      slot_ptr_r    <= slot_ptr_nxt;
      payload_r     <= payload_nxt;
    end
  end

  // report decode
  assign id_ok    = merged[PAY_W-1 -: 6] == MSG_ID_POSITION;
  assign rot_code = $signed(merged[PAY_W-1-42 -: 8]);
  assign rot_mag  = rot_code[7] ? 7'(-rot_code) : rot_code[6:0];
  assign rot_q    = TURN_LUT[rot_mag];

  always_comb begin
    priority if (rot_code == ROT_NONE) begin
      turn_val = '0;
    end else if (rot_code == ROT_FAST_L) begin
      turn_val = TURN_FAST_L;
    end else if (rot_code == ROT_FAST_R) begin
      turn_val = TURN_FAST_R;
    end else if (rot_code[7]) begin
      turn_val = -$signed({1'b0, rot_q});
    end else begin
      turn_val = $signed({1'b0, rot_q});
    end
  end

  assign lon_raw  = $signed(merged[PAY_W-1-61 -: 28]);
  assign lon_wide = LON_WRAP - 29'(lon_raw);
  assign lon_val  = (lon_raw > LON_FOLD) ? lon_wide[27:0] : lon_raw;

  assign out_valid_nxt = load_out ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (id_ok) begin
        out_status_r  <= STATUS_OK;
        out_repeat_r  <= merged[PAY_W-1-6 -: 2];
        out_mmsi_r    <= merged[PAY_W-1-8 -: 30];
        out_nav_r     <= merged[PAY_W-1-38 -: 4];
        out_turn_r    <= turn_val;
        out_speed_r   <= merged[PAY_W-1-50 -: 10];
        out_flags_r   <= {merged[PAY_W-1-148], merged[PAY_W-1-60]};
        out_lon_r     <= lon_val;
        out_lat_r     <= $signed(merged[PAY_W-1-89 -: 27]);
        out_course_r  <= merged[PAY_W-1-116 -: 12];
        out_heading_r <= merged[PAY_W-1-128 -: 9];
        out_second_r  <= merged[PAY_W-1-137 -: 6];
      end else begin
        out_status_r  <= STATUS_BAD_ID;
        out_repeat_r  <= '0;
        out_mmsi_r    <= '0;
        out_nav_r     <= '0;
        out_turn_r    <= '0;
        out_speed_r   <= '0;
        out_flags_r   <= '0;
        out_lon_r     <= '0;
        out_lat_r     <= '0;
        out_course_r  <= '0;
        out_heading_r <= '0;
        out_second_r  <= '0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.repeat_count = out_repeat_r;
  assign out_if.mmsi         = out_mmsi_r;
  assign out_if.nav_status   = out_nav_r;
  assign out_if.rot_rate     = out_turn_r;
  assign out_if.speed        = out_speed_r;
  assign out_if.flags        = out_flags_r;
  assign out_if.lon_units    = out_lon_r;
  assign out_if.lat_units    = out_lat_r;
  assign out_if.course       = out_course_r;
  assign out_if.heading      = out_heading_r;
  assign out_if.time_second  = out_second_r;

`ifndef SYNTHESIS
  // payload is only open after the fifth header comma
  a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> comma_count_r == HEADER_COMMAS)
    else $error("payload open without five header commas");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_ptr_r <= PTR_W'(NSLOT))
    else $error("slot pointer beyond payload store");

  // a message end leaves a clean state for the next message
  a_msg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_m_last_r |=> slot_ptr_r == '0 && !in_payload_r &&
                               comma_count_r == '0 && payload_r == '0)
    else $error("state not cleared after message end");

  a_bad_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STATUS_BAD_ID |->
      out_mmsi_r == '0 && out_lon_r == '0 && out_turn_r == '0)
    else $error("report with wrong id carries nonzero fields");

  // a stalled report is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |-> !load_out)
    else $error("report loaded over a pending one");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for ais_vdm_position_report_decoder. streams nmea sentence
// characters in, decodes the same stream in-bench and checks every report.
// depends on aisvdm_pkg, aisvdm_in_if / aisvdm_out_if and the decoder rtl.

module tb_top;
  import aisvdm_pkg::*;

  localparam int NO_ACCEPT_LIMIT = 3000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int HOLD_CYCLES     = 300;
  localparam int PAY_CHARS       = CAP_BITS / 6;

  typedef bit [0:CAP_BITS-1] payload_t;

  typedef struct packed {
    status_t     status;
    repeat_t     repeat_count;
    mmsi_t       mmsi;
    nav_status_t nav_status;
    rot_rate_t   rot_rate;
    speed_t      speed;
    flags_t      flags;
    lon_t        lon_units;
    lat_t        lat_units;
    course_t     course;
    heading_t    heading;
    second_t     time_second;
  } report_t;

  logic clk;
  logic rst_n;

  aisvdm_in_if  in_if ();
  aisvdm_out_if out_if ();

  ais_vdm_position_report_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // in-bench sentence decoder state
  int unsigned hdr_commas;
  bit          taking_payload;
  int unsigned fill_ptr;
  payload_t    pay_store;

  report_t     pending_reports[$];
  byte unsigned line_buf[$];

  int errors = 0;
  int chars_sent = 0;
  int reports_made = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned pay_field(int start, int len);
    longint unsigned v;
    v = '0;
    for (int i = 0; i < len; i++) v = {v[62:0], pay_store[start + i]};
    return v;
  endfunction

  function automatic longint pay_signed(int start, int len);
    longint unsigned u;
    u = pay_field(start, len);
    if (u[len - 1]) return longint'(u) - (longint'(1) << len);
    return longint'(u);
  endfunction

  // (c / 4.733)^2 / 60 deg/s scaled by 1024, magnitude rounded half up
  function automatic rot_rate_t turn_from_code(logic signed [7:0] c);
    longint          cs;
    longint unsigned mag;
    longint unsigned q;
    longint          t;
    if (c == ROT_NONE) return '0;
    if (c == ROT_FAST_L) return TURN_FAST_L;
    if (c == ROT_FAST_R) return TURN_FAST_R;
    cs  = c;
    mag = (cs < 0) ? -cs : cs;
    q   = (64'd2 * mag * mag * TURN_NUM + TURN_DEN) / (64'd2 * TURN_DEN);
    t   = (cs < 0) ? -longint'(q) : longint'(q);
    return t[14:0];
  endfunction

  function automatic void clear_message();
    pay_store      = '0;
    fill_ptr       = 0;
    hdr_commas     = 0;
    taking_payload = 1'b0;
  endfunction

  task automatic track_char(input ch_t c, input bit s_last, input bit m_last);
    logic [7:0] v;
    longint     lon;
    longint     lat;
    report_t    r;
    if (taking_payload) begin
      if (c == CH_COMMA) begin
        taking_payload = 1'b0;
      end else begin
        v = c - CH_ZERO;
        if (v > ARMOR_GAP) v = v - ARMOR_SKIP;
        for (int i = 5; i >= 0; i--) begin
          if (fill_ptr < CAP_BITS) begin
            pay_store[fill_ptr] = v[i];
            fill_ptr++;
          end
        end
      end
    end else if (hdr_commas < HEADER_COMMAS && c == CH_COMMA) begin
      hdr_commas++;
      if (hdr_commas == HEADER_COMMAS) taking_payload = 1'b1;
    end
    if (s_last || m_last) begin
      hdr_commas     = 0;
      taking_payload = 1'b0;
    end
    if (m_last) begin
      r = '0;
      if (pay_field(0, 6) != longint'(MSG_ID_POSITION)) begin
        r.status = STATUS_BAD_ID;
      end else begin
        r.status       = STATUS_OK;
        r.repeat_count = repeat_t'(pay_field(6, 2));
        r.mmsi         = mmsi_t'(pay_field(8, 30));
        r.nav_status   = nav_status_t'(pay_field(38, 4));
        r.rot_rate     = turn_from_code(8'(pay_field(42, 8)));
        r.speed        = speed_t'(pay_field(50, 10));
        r.flags        = {pay_store[148], pay_store[60]};
        lon = pay_signed(61, 28);
        if (lon > longint'(LON_FOLD)) lon = longint'(LON_WRAP) - lon;
        r.lon_units    = lon[27:0];
        lat = pay_signed(89, 27);
        r.lat_units    = lat[26:0];
        r.course       = course_t'(pay_field(116, 12));
        r.heading      = heading_t'(pay_field(128, 9));
        r.time_second  = second_t'(pay_field(137, 6));
      end
      pending_reports.push_back(r);
      reports_made++;
      clear_message();
    end
  endtask

  // one character word per handshake; returns just after the accepting edge
  task automatic send_char(input ch_t c, input bit s_last, input bit m_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.ch            <= c;
    in_if.sentence_last <= s_last;
    in_if.message_last  <= m_last;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    chars_sent++;
    track_char(c, s_last, m_last);
  endtask

  task automatic send_line(input bit s_last, input bit m_last);
    int n;
    n = line_buf.size();
    for (int i = 0; i < n; i++)
      send_char(line_buf[i], s_last && (i == n - 1), m_last && (i == n - 1));
    line_buf.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  function automatic ch_t armor(bit [5:0] v);
    if (8'(v) < ARMOR_GAP) return 8'(v) + CH_ZERO;
    return 8'(v) + CH_ZERO + ARMOR_SKIP;
  endfunction

  // six-bit groups past the payload register get random content
  task automatic add_payload(input payload_t p, input int first, input int n);
    bit [5:0] v;
    for (int k = first; k < first + n; k++) begin
      if (6 * k + 5 < CAP_BITS) v = p[6 * k +: 6];
      else v = 6'($urandom_range(0, 63));
      line_buf.push_back(armor(v));
    end
  endtask

  function automatic payload_t make_payload(bit [5:0] id, repeat_t rep, mmsi_t id_num,
                                            nav_status_t nav, logic [7:0] rot, speed_t spd,
                                            flags_t flg, logic [27:0] lon, logic [26:0] lat,
                                            course_t crs, heading_t hdg, second_t sec);
    payload_t p;
    p = '0;
    p[0:5]     = id;
    p[6:7]     = rep;
    p[8:37]    = id_num;
    p[38:41]   = nav;
    p[42:49]   = rot;
    p[50:59]   = spd;
    p[60]      = flg[0];
    p[61:88]   = lon;
    p[89:115]  = lat;
    p[116:127] = crs;
    p[128:136] = hdg;
    p[137:142] = sec;
    p[148]     = flg[1];
    return p;
  endfunction

  function automatic payload_t rand_payload(bit good_id);
    payload_t p;
    int       id;
    for (int i = 0; i < CAP_BITS; i++) p[i] = 1'($urandom_range(0, 1));
    if (good_id) begin
      p[0:5] = MSG_ID_POSITION;
    end else begin
      id = $urandom_range(0, 62);
      if (id >= 1) id++;
      p[0:5] = 6'(id);
    end
    return p;
  endfunction

  task automatic send_report(input payload_t p, input int nchars, input int nparts,
                             input bit last_sl);
    int    first;
    int    cnt;
    int    seq;
    string talker;
    string chan;
    first  = 0;
    seq    = $urandom_range(0, 9);
    talker = $urandom_range(0, 1) ? "M" : "O";
    chan   = $urandom_range(0, 1) ? "A" : "B";
    for (int part = 0; part < nparts; part++) begin
      cnt = (part == nparts - 1) ? nchars - first : nchars / nparts;
      add_str($sformatf("!AIVD%s,%0d,%0d,%0d,%s,", talker, nparts, part + 1, seq, chan));
      add_payload(p, first, cnt);
      add_str(",0*5C");
      first += cnt;
      if (part == nparts - 1) send_line(last_sl, 1'b1);
      else send_line(1'b1, 1'b0);
    end
  endtask

  task automatic send_bare_message();
    add_str(",,,,,");
    add_payload(rand_payload($urandom_range(0, 9) != 0), 0, $urandom_range(1, 12));
    send_line(1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic send_noise_line();
    int n;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(0, 255)));
    send_line(1'b1, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_field_extremes();
    logic [7:0]  rot_codes [4] = '{8'h80, 8'h81, 8'h7F, 8'hFF};
    logic [27:0] lon_vals  [4] = '{28'd108000001, 28'd108000000, 28'h8000000, 28'h7FFFFFF};
    logic [26:0] lat_vals  [4] = '{27'h3FFFFFF, 27'h4000000, 27'h7FFFFFF, 27'd0};
    for (int i = 0; i < 4; i++)
      send_report(make_payload(MSG_ID_POSITION, 2'($urandom), 30'($urandom), 4'($urandom),
                               rot_codes[i], 10'($urandom), 2'(i), lon_vals[i], lat_vals[i],
                               12'($urandom), 9'($urandom), 6'(60 + i)),
                  PAY_CHARS, 1, 1'b1);
  endtask

  task automatic test_message_ids();
    send_report(make_payload(6'd0, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), PAY_CHARS, 1,
                1'b1);
    send_report(make_payload(6'd63, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), PAY_CHARS, 1,
                1'b1);
  endtask

  task automatic test_sentence_framing();
    // only four header commas: nothing of this sentence lands in the payload
    add_str("!AIVDM,1,1,A,");
    add_payload(rand_payload(1'b0), 0, 8);
    add_str("*5C");
    send_line(1'b1, 1'b0);
    // commas and text after the payload comma are ignored
    add_str("!AIVDM,1,1,,A,");
    add_payload(rand_payload(1'b1), 0, 12);
    add_str(",0*5C,!AIVDM,1,1,,A,,extra");
    send_line(1'b1, 1'b1);
    // payload longer than the register, then shorter with message end mid-sentence
    send_report(rand_payload(1'b1), PAY_CHARS + 2, 1, 1'b1);
    send_report(rand_payload(1'b1), 10, 1, 1'b0);
    // message ends on its first character, then on the fifth header comma
    add_str("!");
    send_line(1'b0, 1'b1);
    add_str("!AIVDM,1,1,,A,");
    send_line(1'b1, 1'b1);
    // payload split over three sentences
    send_report(rand_payload(1'b1), 15, 3, 1'b1);
    // characters outside the armor alphabet inside the payload
    add_str("!AIVDM,1,1,,B,");
    line_buf.push_back(armor(6'd1));
    for (int i = 0; i < 8; i++) line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hAA);
    line_buf.push_back(8'h55);
    line_buf.push_back(8'h80);
    line_buf.push_back(8'h7F);
    line_buf.push_back(8'h2B);
    line_buf.push_back(8'h58);
    line_buf.push_back(8'h59);
    add_str(",0*5C");
    send_line(1'b1, 1'b1);
    // message ends on the comma that closes the payload
    add_str("!AIVDM,1,1,,A,");
    add_payload(rand_payload(1'b1), 0, 10);
    add_str(",");
    send_line(1'b0, 1'b1);
  endtask

  task automatic test_random_traffic(input int src_pct, input int dst_pct);
    int chars0;
    int reports0;
    int pick;
    int nchars;
    send_idle_pct = src_pct;
    recv_idle_pct = dst_pct;
    chars0   = chars_sent;
    reports0 = reports_made;
    while (chars_sent - chars0 < 40 || reports_made - reports0 < 2) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: nchars = PAY_CHARS;
          6, 7:             nchars = $urandom_range(1, PAY_CHARS - 1);
          default:          nchars = $urandom_range(PAY_CHARS + 1, 40);
        endcase
        send_report(rand_payload(pick < 62), nchars,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1,
                    1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        send_bare_message();
      end else begin
        send_noise_line();
      end
    end
  endtask

  // receiver holds off while short messages keep coming, so the input backs up
  task automatic test_report_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = HOLD_CYCLES;
    repeat (6) send_bare_message();
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // report receiver
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // report checker
  initial begin
    report_t got;
    report_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.status       = status_t'(out_if.status);
        got.repeat_count = out_if.repeat_count;
        got.mmsi         = out_if.mmsi;
        got.nav_status   = out_if.nav_status;
        got.rot_rate     = out_if.rot_rate;
        got.speed        = out_if.speed;
        got.flags        = out_if.flags;
        got.lon_units    = out_if.lon_units;
        got.lat_units    = out_if.lat_units;
        got.course       = out_if.course;
        got.heading      = out_if.heading;
        got.time_second  = out_if.time_second;
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: report with none expected, expected none actual %h", $time, got);
        end else begin
          want = pending_reports.pop_front();
          check_field("status", longint'(want.status), longint'(got.status));
          check_field("repeat_count", longint'(want.repeat_count),
                      longint'(got.repeat_count));
          check_field("mmsi", longint'(want.mmsi), longint'(got.mmsi));
          check_field("nav_status", longint'(want.nav_status), longint'(got.nav_status));
          check_field("rot_rate", longint'($signed(want.rot_rate)),
                      longint'($signed(got.rot_rate)));
          check_field("speed", longint'(want.speed), longint'(got.speed));
          check_field("flags", longint'(want.flags), longint'(got.flags));
          check_field("lon_units", longint'($signed(want.lon_units)),
                      longint'($signed(got.lon_units)));
          check_field("lat_units", longint'($signed(want.lat_units)),
                      longint'($signed(got.lat_units)));
          check_field("course", longint'(want.course), longint'(got.course));
          check_field("heading", longint'(want.heading), longint'(got.heading));
          check_field("time_second", longint'(want.time_second), longint'(got.time_second));
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin
    forever begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= NO_ACCEPT_LIMIT) begin
          $display("ais_vdm_position_report_decoder: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    clear_message();
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.ch            <= '0;
    in_if.sentence_last <= 1'b0;
    in_if.message_last  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 78;
    test_field_extremes();
    test_message_ids();
    test_sentence_framing();
    test_random_traffic(33, 78);
    test_random_traffic(78, 33);
    test_random_traffic(0, 0);
    test_report_backpressure();

    in_if.valid <= 1'b0;
    recv_idle_pct = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ais_vdm_position_report_decoder: match");
    end else begin
      $display("ais_vdm_position_report_decoder: mismatch");
    end
    $finish;
  end

endmodule
